// ----- hw/rtl/tlen_pkg.sv -----
// types, constants and step functions for the line ending normalizer
`default_nettype none

package tlen_pkg;

    localparam int MAX_RES = 8;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [2:0][7:0] BOM_BYTES = {8'hBF, 8'hBB, 8'hEF};

    // target modes, any other code behaves as keep
    localparam logic [1:0] MODE_KEEP = 2'd0;
    localparam logic [1:0] MODE_UNIX = 2'd1;
    localparam logic [1:0] MODE_WIN  = 2'd2;

    // kinds of line end found in the input
    localparam logic [1:0] LE_CRLF = 2'd0;
    localparam logic [1:0] LE_LF   = 2'd1;
    localparam logic [1:0] LE_CR   = 2'd2;

    // range rule for the next continuation byte
    localparam logic [2:0] CLS_ANY = 3'd0;
    localparam logic [2:0] CLS_A0  = 3'd1;
    localparam logic [2:0] CLS_9F  = 3'd2;
    localparam logic [2:0] CLS_90  = 3'd3;
    localparam logic [2:0] CLS_8F  = 3'd4;

    // format flag bit positions
    localparam int FL_CH  = 0;
    localparam int FL_BOM = 1;
    localparam int FL_RN  = 2;
    localparam int FL_N   = 3;
    localparam int FL_R   = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
        logic       not_utf8;
        logic       changed;
        logic       saw_bom;
        logic       saw_crlf;
        logic       saw_lf;
        logic       saw_cr;
    } t_out;

    typedef struct packed {
        logic       has;
        logic [7:0] b;
    } t_ent;

    typedef struct packed {
        logic [1:0] bom_cnt;
        logic       bom_done;
        logic       held_cr;
        logic [1:0] left;
        logic [2:0] cls;
        logic       err;
        logic [4:0] flags;
    } t_state;

    typedef struct packed {
        t_state                   st;
        t_ent [MAX_RES-1:0]       ent;
        logic [CNT_W-1:0]         n;
    } t_work;

    // results of one input beat, handed from the step stage to the emitter
    typedef struct packed {
        logic [CNT_W-1:0]         n;
        t_ent [MAX_RES-1:0]       ent;
        logic                     err;
        logic                     eof;
        logic [4:0]               flags;
    } t_step;

    function automatic t_work f_put(t_work w, logic has, logic [7:0] b);
        t_work r;
        r = w;
        if (w.n < CNT_W'(MAX_RES)) begin
            r.ent[w.n[IDX_W-1:0]].has = has;
            r.ent[w.n[IDX_W-1:0]].b   = has ? b : 8'h00;
            r.n = w.n + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic t_work f_put_bom(t_work w);
        t_work r;
        r = w;
        r.st.flags[FL_BOM] = 1'b1;
        r = f_put(r, 1'b1, BOM_BYTES[0]);
        r = f_put(r, 1'b1, BOM_BYTES[1]);
        r = f_put(r, 1'b1, BOM_BYTES[2]);
        return r;
    endfunction

    function automatic t_work f_line_end(t_work w, logic [1:0] mode, logic [1:0] kind);
        t_work r;
        r = w;
        if (mode == MODE_UNIX) begin
            if (kind != LE_LF) r.st.flags[FL_CH] = 1'b1;
            r.st.flags[FL_N] = 1'b1;
            r = f_put(r, 1'b1, CH_LF);
        end else if (mode == MODE_WIN) begin
            if (kind != LE_CRLF) r.st.flags[FL_CH] = 1'b1;
            r.st.flags[FL_RN] = 1'b1;
            r = f_put(r, 1'b1, CH_CR);
            r = f_put(r, 1'b1, CH_LF);
        end else if (kind == LE_CRLF) begin
            r.st.flags[FL_RN] = 1'b1;
            r = f_put(r, 1'b1, CH_CR);
            r = f_put(r, 1'b1, CH_LF);
        end else if (kind == LE_LF) begin
            r.st.flags[FL_N] = 1'b1;
            r = f_put(r, 1'b1, CH_LF);
        end else begin
            r.st.flags[FL_R] = 1'b1;
            r = f_put(r, 1'b1, CH_CR);
        end
        return r;
    endfunction

    function automatic t_work f_fail(t_work w);
        t_work r;
        r = w;
        r.st.err     = 1'b1;
        r.st.held_cr = 1'b0;
        r = f_put(r, 1'b0, 8'h00);
        return r;
    endfunction

    function automatic t_work f_content(t_work w, logic [1:0] mode, logic [7:0] b);
        t_work      r;
        logic [7:0] lo;
        logic [7:0] hi;
        r  = w;
        lo = 8'h80;
        hi = 8'hBF;
        if (w.st.err) return r;
        if (w.st.left != 2'd0) begin
            if (w.st.cls == CLS_A0)      lo = 8'hA0;
            else if (w.st.cls == CLS_9F) hi = 8'h9F;
            else if (w.st.cls == CLS_90) lo = 8'h90;
            else if (w.st.cls == CLS_8F) hi = 8'h8F;
            if (b < lo || b > hi) return f_fail(r);
            r = f_put(r, 1'b1, b);
            r.st.left = w.st.left - 2'd1;
            r.st.cls  = CLS_ANY;
            return r;
        end
        if (w.st.held_cr) begin
            r.st.held_cr = 1'b0;
            if (b == CH_LF) return f_line_end(r, mode, LE_CRLF);
            r = f_line_end(r, mode, LE_CR);
        end
        if (b == CH_CR) begin
            r.st.held_cr = 1'b1;
            return r;
        end
        if (b == CH_LF) return f_line_end(r, mode, LE_LF);
        if (b < 8'h80) return f_put(r, 1'b1, b);
        // lead byte sets the length and the range of the second byte
        if (b >= 8'hC2 && b <= 8'hDF) begin
            r.st.left = 2'd1; r.st.cls = CLS_ANY;
        end else if (b == 8'hE0) begin
            r.st.left = 2'd2; r.st.cls = CLS_A0;
        end else if (b == 8'hED) begin
            r.st.left = 2'd2; r.st.cls = CLS_9F;
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
            r.st.left = 2'd2; r.st.cls = CLS_ANY;
        end else if (b == 8'hF0) begin
            r.st.left = 2'd3; r.st.cls = CLS_90;
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
            r.st.left = 2'd3; r.st.cls = CLS_ANY;
        end else if (b == 8'hF4) begin
            r.st.left = 2'd3; r.st.cls = CLS_8F;
        end else begin
            return f_fail(r);
        end
        return f_put(r, 1'b1, b);
    endfunction

    // partial bom turns out to be content, windows mode inserts a bom first
    function automatic t_work f_bom_missing(t_work w, logic [1:0] mode);
        t_work      r;
        logic [1:0] cnt;
        r   = w;
        cnt = w.st.bom_cnt;
        r.st.bom_done = 1'b1;
        if (mode == MODE_WIN) begin
            r = f_put_bom(r);
            r.st.flags[FL_CH] = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            if (i < int'(cnt)) r = f_content(r, mode, BOM_BYTES[i]);
        end
        r.st.bom_cnt = 2'd0;
        return r;
    endfunction

    function automatic t_work f_step(t_state st, logic [1:0] mode, logic [7:0] b, logic eof);
        t_work      w;
        logic [1:0] k;
        logic [1:0] nk;
        w.st  = st;
        w.ent = '0;
        w.n   = '0;
        k     = (st.bom_cnt < 2'd3) ? st.bom_cnt : 2'd0;
        nk    = k + 2'd1;
        if (!st.err) begin
            if (!st.bom_done) begin
                if (b == BOM_BYTES[k]) begin
                    w.st.bom_cnt = nk;
                    if (nk == 2'd3) begin
                        w.st.bom_done = 1'b1;
                        w.st.bom_cnt  = 2'd0;
                        if (mode == MODE_UNIX) w.st.flags[FL_CH] = 1'b1;
                        else                   w = f_put_bom(w);
                    end else if (eof) begin
                        w = f_bom_missing(w, mode);
                    end
                end else begin
                    w = f_bom_missing(w, mode);
                    w = f_content(w, mode, b);
                end
            end else begin
                w = f_content(w, mode, b);
            end
            if (eof && !w.st.err) begin
                if (w.st.held_cr) begin
                    w.st.held_cr = 1'b0;
                    w = f_line_end(w, mode, LE_CR);
                end
                if (w.st.left != 2'd0) w = f_fail(w);
            end
        end
        if (eof && w.n == '0) w = f_put(w, 1'b0, 8'h00);
        // after an error only the end of file still reports
        if (st.err && !eof) w.n = '0;
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tlen_core.sv -----
// input register, step logic and stream state of the line ending normalizer
`default_nettype none

module tlen_core
    import tlen_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_mode,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_data,
    output logic            o_step_valid,
    output t_step           o_step,
    input  wire logic       i_step_free
);

    logic   r_in_valid;
    t_in    r_in;
    t_state r_state;
    t_state n_state;
    t_work  w;
    logic   step_take;

    always_comb begin
        w = f_step(r_state, i_mode, r_in.data_byte, r_in.end_of_file);
    end

    // a silent beat needs no room in the emitter
    assign step_take    = r_in_valid && (w.n == '0 || i_step_free);
    assign o_step_valid = step_take && (w.n != '0);
    assign o_ready      = !r_in_valid || step_take;

    assign o_step.n     = w.n;
    assign o_step.ent   = w.ent;
    assign o_step.err   = w.st.err;
    assign o_step.eof   = r_in.end_of_file;
    assign o_step.flags = w.st.flags;

    assign n_state = r_in.end_of_file ? '0 : w.st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (step_take) r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_data;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tlen_emit.sv -----
// result buffer and output register, one result beat per cycle while the receiver is ready
`default_nettype none

module tlen_emit
    import tlen_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step_valid,
    input  wire t_step i_step,
    output logic      o_step_free,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    logic             r_buf_valid;
    t_step            r_buf;
    logic [IDX_W-1:0] r_idx;
    logic             r_o_valid;
    t_out             r_o_data;
    t_out             n_o_data;
    logic [CNT_W-1:0] last_pos;
    logic             buf_last;
    logic             buf_move;
    logic             out_load;
    logic             at_end;
    t_ent             ent;

    assign out_load    = !r_o_valid || i_ready;
    assign last_pos    = r_buf.n - CNT_W'(1);
    assign buf_last    = (r_idx == last_pos[IDX_W-1:0]);
    assign buf_move    = r_buf_valid && out_load;
    assign o_step_free = !r_buf_valid || (buf_move && buf_last);

    // status and flags ride only on the final result of a beat
    always_comb begin
        ent                  = r_buf.ent[r_idx];
        at_end               = buf_last && r_buf.eof;
        n_o_data.has_byte    = ent.has;
        n_o_data.out_byte    = ent.b;
        n_o_data.last_of_run = buf_last;
        n_o_data.stream_done = at_end;
        n_o_data.not_utf8    = buf_last && r_buf.err;
        n_o_data.changed     = at_end && r_buf.flags[FL_CH];
        n_o_data.saw_bom     = at_end && r_buf.flags[FL_BOM];
        n_o_data.saw_crlf    = at_end && r_buf.flags[FL_RN];
        n_o_data.saw_lf      = at_end && r_buf.flags[FL_N];
        n_o_data.saw_cr      = at_end && r_buf.flags[FL_R];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
            r_idx       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (out_load) r_o_valid <= r_buf_valid;
            if (i_step_valid) begin
                r_buf_valid <= 1'b1;
                r_idx       <= '0;
            end else if (buf_move && buf_last) begin
                r_buf_valid <= 1'b0;
            end else if (buf_move) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step_valid) r_buf <= i_step;
        if (buf_move) r_o_data <= n_o_data;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

`default_nettype wire

// ----- hw/rtl/text_line_ending_normalizer.sv -----
// Line ending normalizer with UTF-8 BOM handling and UTF-8 validation.
//
// Input channel (i_valid / o_ready, payload i_data) takes one file byte per
// beat, end_of_file marking the last byte. Output channel (o_valid / i_ready,
// payload o_data) gives the rewritten stream, one result per beat; a byte
// may cause zero to six results. The user writes the target mode (keep,
// unix, windows) via i_cfg_we / i_cfg_data only between files, unenforced.
//
// The first result of a byte passes from the input register through the
// step logic into the result buffer and then the output register before
// it shows on o_data. The result buffer drains one result per cycle
// while the receiver takes them, and the results of the next byte enter
// it as the last result of the previous byte leaves. Bytes that give no
// result (held CR, leading BOM bytes) need no room in the result buffer.
//
// Reset clears the mode to keep and the stream state to the start of a
// file. When the receiver stalls the output register holds its result and
// backpressure reaches o_ready once the buffer and input register are full.
`default_nettype none

module text_line_ending_normalizer
    import tlen_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out            o_data
);

    logic [1:0] r_mode;
    logic       step_valid;
    t_step      step;
    logic       step_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_KEEP;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    tlen_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_step_valid (step_valid),
        .o_step       (step),
        .i_step_free  (step_free)
    );

    tlen_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (step_valid),
        .i_step       (step),
        .o_step_free  (step_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tlen_checker.sv -----
// port level checks for the line ending normalizer, bound to the top level
`default_nettype none

module tlen_checker
    import tlen_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // a result without a byte is an error or end marker and closes its run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.has_byte |-> o_data.last_of_run && o_data.out_byte == 8'h00)
        else $error("empty result not last of run");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.stream_done |-> o_data.last_of_run)
        else $error("stream end not last of run");

    // status fields only on the closing results
    a_flags_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.stream_done |-> !o_data.changed && !o_data.saw_bom
            && !o_data.saw_crlf && !o_data.saw_lf && !o_data.saw_cr)
        else $error("format flags outside stream end");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.not_utf8 |-> o_data.last_of_run)
        else $error("error flag before end of run");

endmodule

bind text_line_ending_normalizer tlen_checker u_tlen_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire
